FILE: src/tdsc_pkg.sv
// Shared types, constants and helpers of the table-driven sparse convolution block.
package tdsc_pkg;

  localparam int unsigned MAX_IN_CHANNELS   = 16;
  localparam int unsigned MAX_OUT_CHANNELS  = 16;
  localparam int unsigned MAX_IN_PIXELS     = 1024;
  localparam int unsigned MAX_OUT_PIXELS    = 1024;
  localparam int unsigned MAX_TAPS          = 16;
  localparam int unsigned MAX_TABLE_ENTRIES = 16384;

  localparam int unsigned ACT_DEPTH = MAX_IN_CHANNELS * MAX_IN_PIXELS;
  localparam int unsigned WGT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_TAPS;
  localparam int unsigned ACC_DEPTH = MAX_OUT_CHANNELS * MAX_OUT_PIXELS;

  localparam int unsigned ACT_AW = $clog2(ACT_DEPTH);
  localparam int unsigned WGT_AW = $clog2(WGT_DEPTH);
  localparam int unsigned CNT_AW = $clog2(MAX_IN_PIXELS);
  localparam int unsigned TBL_AW = $clog2(MAX_TABLE_ENTRIES);
  localparam int unsigned ACC_AW = $clog2(ACC_DEPTH);

  typedef enum logic [2:0] {
    MODE_ACT  = 3'd0,
    MODE_WGT  = 3'd1,
    MODE_CNT  = 3'd2,
    MODE_TBL  = 3'd3,
    MODE_MSK  = 3'd4,
    MODE_CMP  = 3'd5,
    MODE_READ = 3'd6,
    MODE_NOP  = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    CFG_IN_CH   = 3'd0,
    CFG_OUT_CH  = 3'd1,
    CFG_IN_PIX  = 3'd2,
    CFG_OUT_PIX = 3'd3,
    CFG_TAPS    = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_READW, ST_CLEAR, ST_PIX, ST_PIXW, ST_ENT, ST_ENTW,
    ST_MUL, ST_ACC, ST_MASK, ST_MASKW, ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [13:0]        index;
    logic signed [31:0] value;
    logic [3:0]         tap;
  } in_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic               is_done;
  } out_t;

  typedef struct packed {
    logic load;
    logic clr_init;
    logic clr_wr;
    logic cmp_init;
    logic pix_adv;
    logic ent_init;
    logic ent_adv;
    logic mul;
    logic acc_wr;
    logic msk_init;
    logic msk_wr;
    logic acc_sel_rd;
    logic out_read;
    logic out_done;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic act_nz;
    logic cnt_nz;
    logic loop_last;
    logic ent_ovf;
    logic ent_ok;
    logic ent_last;
    logic msk_last;
    logic out_busy;
  } sts_t;

  function automatic logic [4:0] sat_ch(input logic [4:0] v);
    if (v == 5'd0) return 5'd1;
    if (v > 5'd16) return 5'd16;
    return v;
  endfunction

  function automatic logic [10:0] sat_px(input logic [10:0] v);
    if (v == 11'd0) return 11'd1;
    if (v > 11'd1024) return 11'd1024;
    return v;
  endfunction

endpackage

FILE: src/tdsc_ctrl.sv
// Controller state machine of the sparse convolution block.
module tdsc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [2:0]         in_mode,
  output logic               in_ready,
  input  tdsc_pkg::sts_t     sts,
  output tdsc_pkg::cmd_t     cmd
);

  tdsc_pkg::state_t state_r, state_nxt;
  logic is_result;
  logic in_fire;
  logic ent_done;

  assign is_result = (in_mode == tdsc_pkg::MODE_CMP) || (in_mode == tdsc_pkg::MODE_READ);
  assign in_ready  = (state_r == tdsc_pkg::ST_IDLE) && (!sts.out_busy || !is_result);
  assign in_fire   = in_valid && in_ready;
  assign ent_done  = sts.loop_last ? 1'b1 : 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdsc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tdsc_pkg::ST_IDLE: begin
        if (in_fire && in_mode == tdsc_pkg::MODE_CMP) begin
          state_nxt = tdsc_pkg::ST_CLEAR;
        end else if (in_fire && in_mode == tdsc_pkg::MODE_READ) begin
          state_nxt = tdsc_pkg::ST_READ;
        end
      end
      tdsc_pkg::ST_READ:  state_nxt = tdsc_pkg::ST_READW;
      tdsc_pkg::ST_READW: state_nxt = tdsc_pkg::ST_IDLE;
      tdsc_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_nxt = tdsc_pkg::ST_PIX;
      end
      tdsc_pkg::ST_PIX:   state_nxt = tdsc_pkg::ST_PIXW;
      tdsc_pkg::ST_PIXW: begin
        if (sts.act_nz && sts.cnt_nz) begin
          state_nxt = tdsc_pkg::ST_ENT;
        end else begin
          state_nxt = ent_done ? tdsc_pkg::ST_MASK : tdsc_pkg::ST_PIX;
        end
      end
      tdsc_pkg::ST_ENT: begin
        if (sts.ent_ovf) begin
          state_nxt = ent_done ? tdsc_pkg::ST_MASK : tdsc_pkg::ST_PIX;
        end else begin
          state_nxt = tdsc_pkg::ST_ENTW;
        end
      end
      tdsc_pkg::ST_ENTW, tdsc_pkg::ST_ACC: begin
        if (state_r == tdsc_pkg::ST_ENTW && sts.ent_ok) begin
          state_nxt = tdsc_pkg::ST_MUL;
        end else if (!sts.ent_last) begin
          state_nxt = tdsc_pkg::ST_ENT;
        end else begin
          state_nxt = ent_done ? tdsc_pkg::ST_MASK : tdsc_pkg::ST_PIX;
        end
      end
      tdsc_pkg::ST_MUL:   state_nxt = tdsc_pkg::ST_ACC;
      tdsc_pkg::ST_MASK:  state_nxt = tdsc_pkg::ST_MASKW;
      tdsc_pkg::ST_MASKW: begin
        state_nxt = sts.msk_last ? tdsc_pkg::ST_DONE : tdsc_pkg::ST_MASK;
      end
      tdsc_pkg::ST_DONE:  state_nxt = tdsc_pkg::ST_IDLE;
      default:            state_nxt = tdsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      tdsc_pkg::ST_IDLE: begin
        cmd.load     = in_fire;
        cmd.clr_init = in_fire && in_mode == tdsc_pkg::MODE_CMP;
      end
      tdsc_pkg::ST_READ:  cmd.acc_sel_rd = 1'b1;
      tdsc_pkg::ST_READW: begin
        cmd.acc_sel_rd = 1'b1;
        cmd.out_read   = 1'b1;
      end
      tdsc_pkg::ST_CLEAR: begin
        cmd.clr_wr   = 1'b1;
        cmd.cmp_init = sts.clr_last;
      end
      tdsc_pkg::ST_PIXW: begin
        cmd.ent_init = sts.act_nz && sts.cnt_nz;
        cmd.pix_adv  = !(sts.act_nz && sts.cnt_nz);
      end
      tdsc_pkg::ST_ENT:  cmd.pix_adv = sts.ent_ovf;
      tdsc_pkg::ST_ENTW: begin
        cmd.ent_adv = !sts.ent_ok && !sts.ent_last;
        cmd.pix_adv = !sts.ent_ok && sts.ent_last;
      end
      tdsc_pkg::ST_MUL:  cmd.mul = 1'b1;
      tdsc_pkg::ST_ACC: begin
        cmd.acc_wr  = 1'b1;
        cmd.ent_adv = !sts.ent_last;
        cmd.pix_adv = sts.ent_last;
      end
      tdsc_pkg::ST_MASKW: cmd.msk_wr   = 1'b1;
      tdsc_pkg::ST_DONE:  cmd.out_done = 1'b1;
      default: ;
    endcase
    cmd.msk_init = cmd.pix_adv && sts.loop_last;
  end

  a_one_acc_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_wr, cmd.acc_wr, cmd.msk_wr}))
    else $error("accumulator written from two sources");

  a_adv_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ent_adv && cmd.pix_adv))
    else $error("entry and pixel advance together");

  a_done_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_done || cmd.out_read) |-> !sts.out_busy)
    else $error("result register overwritten");

  a_compute_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_mode == tdsc_pkg::MODE_CMP) |=> state_r == tdsc_pkg::ST_CLEAR)
    else $error("compute request did not start clear pass");

endmodule

FILE: src/tdsc_dp.sv
// Datapath of the sparse convolution block: stores, loop counters, multiply-accumulate.
module tdsc_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  tdsc_pkg::in_t   in_data,
  input  logic            cfg_valid,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  input  tdsc_pkg::cmd_t  cmd,
  output tdsc_pkg::sts_t  sts,
  output logic            out_valid,
  input  logic            out_ready,
  output tdsc_pkg::out_t  out_data
);

  // configuration
  logic [4:0]  ic_cfg_r, oc_cfg_r, tap_cfg_r;
  logic [10:0] ip_cfg_r, op_cfg_r;
  logic [4:0]  ic_n, oc_n, t_n;
  logic [10:0] ip_n, op_n;

  // stores
  logic [31:0] act_mem [tdsc_pkg::ACT_DEPTH];
  logic [31:0] wgt_mem [tdsc_pkg::WGT_DEPTH];
  logic [4:0]  cnt_mem [tdsc_pkg::MAX_IN_PIXELS];
  logic [14:0] tbl_mem [tdsc_pkg::MAX_TABLE_ENTRIES];
  logic        msk_mem [tdsc_pkg::ACC_DEPTH];
  logic [31:0] acc_mem [tdsc_pkg::ACC_DEPTH];

  logic [31:0] act_q, w_q, acc_q, prod_r;
  logic [4:0]  cnt_q;
  logic [14:0] tbl_q;
  logic        msk_q;

  // loop counters
  logic [3:0]  oc_r, ic_r;
  logic [9:0]  p_r;
  logic [4:0]  k_r;
  logic [tdsc_pkg::ACT_AW-1:0] act_addr_r;
  logic [14:0] base_r;
  logic [tdsc_pkg::WGT_AW-1:0] wbase_r;
  logic [tdsc_pkg::ACC_AW-1:0] accbase_r;
  logic [tdsc_pkg::ACC_AW-1:0] j_r;
  logic [13:0] idx_r;
  logic        computed_r;

  logic [14:0] ent_e;
  logic        tbl_hi;
  logic [9:0]  tbl_pos;
  logic [3:0]  tbl_tap;
  logic        p_last, ic_last, oc_last;
  logic [tdsc_pkg::WGT_AW-1:0] w_addr;
  logic [tdsc_pkg::ACC_AW-1:0] acc_cmp_addr, acc_raddr, acc_waddr;
  logic [31:0] acc_wdata;
  logic        acc_we;
  logic        out_valid_r;
  tdsc_pkg::out_t out_r;

  assign ic_n = tdsc_pkg::sat_ch(ic_cfg_r);
  assign oc_n = tdsc_pkg::sat_ch(oc_cfg_r);
  assign t_n  = tdsc_pkg::sat_ch(tap_cfg_r);
  assign ip_n = tdsc_pkg::sat_px(ip_cfg_r);
  assign op_n = tdsc_pkg::sat_px(op_cfg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_cfg_r  <= 5'd1;
      oc_cfg_r  <= 5'd1;
      ip_cfg_r  <= 11'd1;
      op_cfg_r  <= 11'd1;
      tap_cfg_r <= 5'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tdsc_pkg::CFG_IN_CH:   ic_cfg_r  <= cfg_data[4:0];
        tdsc_pkg::CFG_OUT_CH:  oc_cfg_r  <= cfg_data[4:0];
        tdsc_pkg::CFG_IN_PIX:  ip_cfg_r  <= cfg_data[10:0];
        tdsc_pkg::CFG_OUT_PIX: op_cfg_r  <= cfg_data[10:0];
        tdsc_pkg::CFG_TAPS:    tap_cfg_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // load writes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (in_data.mode)
        tdsc_pkg::MODE_ACT: act_mem[in_data.index] <= in_data.value;
        tdsc_pkg::MODE_WGT: begin
          if ({18'd0, in_data.index} < tdsc_pkg::WGT_DEPTH)
            wgt_mem[in_data.index[tdsc_pkg::WGT_AW-1:0]] <= in_data.value;
        end
        tdsc_pkg::MODE_CNT: begin
          if ({18'd0, in_data.index} < tdsc_pkg::MAX_IN_PIXELS)
            cnt_mem[in_data.index[tdsc_pkg::CNT_AW-1:0]] <= in_data.value[4:0];
        end
        tdsc_pkg::MODE_TBL: begin
          tbl_mem[in_data.index] <= {(in_data.value[31:10] != 22'd0),
                                     in_data.value[9:0], in_data.tap};
        end
        tdsc_pkg::MODE_MSK: msk_mem[in_data.index] <= in_data.value[0];
        default: ;
      endcase
    end
  end

  assign ent_e   = base_r + {10'd0, k_r};
  assign tbl_hi  = tbl_q[14];
  assign tbl_pos = tbl_q[13:4];
  assign tbl_tap = tbl_q[3:0];
  assign w_addr  = wbase_r + {8'd0, tbl_tap};
  assign acc_cmp_addr = accbase_r + {4'd0, tbl_pos};
  assign acc_raddr    = cmd.acc_sel_rd ? idx_r : acc_cmp_addr;

  always_ff @(posedge clk) begin
    act_q <= act_mem[act_addr_r];
    cnt_q <= cnt_mem[p_r];
    tbl_q <= tbl_mem[ent_e[tdsc_pkg::TBL_AW-1:0]];
    w_q   <= wgt_mem[w_addr];
    acc_q <= acc_mem[acc_raddr];
    msk_q <= msk_mem[j_r];
  end

  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = j_r;
    acc_wdata = '0;
    if (cmd.clr_wr) begin
      acc_we = 1'b1;
    end else if (cmd.msk_wr) begin
      acc_we = !msk_q;
    end else if (cmd.acc_wr) begin
      acc_we    = 1'b1;
      acc_waddr = acc_cmp_addr;
      acc_wdata = acc_q + prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= act_q * w_q;
  end

  assign p_last  = {1'b0, p_r} == ip_n - 11'd1;
  assign ic_last = {1'b0, ic_r} == ic_n - 5'd1;
  assign oc_last = {1'b0, oc_r} == oc_n - 5'd1;

  always_ff @(posedge clk) begin
    if (cmd.load) idx_r <= in_data.index;
    if (cmd.clr_init || cmd.msk_init) begin
      j_r <= '0;
    end else if (cmd.clr_wr || cmd.msk_wr) begin
      j_r <= j_r + tdsc_pkg::ACC_AW'(1);
    end
    if (cmd.ent_init) begin
      k_r <= '0;
    end else if (cmd.ent_adv) begin
      k_r <= k_r + 5'd1;
    end
    if (cmd.cmp_init) begin
      oc_r       <= '0;
      ic_r       <= '0;
      p_r        <= '0;
      act_addr_r <= '0;
      base_r     <= '0;
      wbase_r    <= '0;
      accbase_r  <= '0;
    end else if (cmd.pix_adv) begin
      if (p_last) begin
        p_r     <= '0;
        base_r  <= '0;
        wbase_r <= wbase_r + {{(tdsc_pkg::WGT_AW-5){1'b0}}, t_n};
        if (ic_last) begin
          ic_r       <= '0;
          act_addr_r <= '0;
          oc_r       <= oc_r + 4'd1;
          accbase_r  <= accbase_r + {{(tdsc_pkg::ACC_AW-11){1'b0}}, op_n};
        end else begin
          ic_r       <= ic_r + 4'd1;
          act_addr_r <= act_addr_r + tdsc_pkg::ACT_AW'(1);
        end
      end else begin
        p_r        <= p_r + 10'd1;
        act_addr_r <= act_addr_r + tdsc_pkg::ACT_AW'(1);
        base_r     <= base_r + {10'd0, cnt_q};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      computed_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_done) computed_r <= 1'b1;
      if (cmd.out_done || cmd.out_read) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_done) begin
      out_r.data    <= '0;
      out_r.is_done <= 1'b1;
    end else if (cmd.out_read) begin
      out_r.data    <= computed_r ? acc_q : 32'd0;
      out_r.is_done <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.clr_last  = j_r == tdsc_pkg::ACC_AW'(tdsc_pkg::ACC_DEPTH - 1);
  assign sts.msk_last  = j_r == tdsc_pkg::ACC_AW'(tdsc_pkg::ACC_DEPTH - 1);
  assign sts.act_nz    = act_q != 32'd0;
  assign sts.cnt_nz    = cnt_q != 5'd0;
  assign sts.loop_last = p_last && ic_last && oc_last;
  assign sts.ent_ovf   = ent_e >= 15'(tdsc_pkg::MAX_TABLE_ENTRIES);
  assign sts.ent_ok    = !tbl_hi && ({1'b0, tbl_pos} < op_n) && ({1'b0, tbl_tap} < t_n);
  assign sts.ent_last  = (k_r + 5'd1) == cnt_q;
  assign sts.out_busy  = out_valid_r;

endmodule

FILE: src/table_driven_sparse_conv_forward.sv
// Top level of the table-driven sparse scatter convolution block.
// Load requests (activation, weight, entry count, table entry, keep mask) are written
// into their stores as they are accepted, even while a result waits at the output. A
// read request passes READ and READW through the registered accumulator memory port. A
// compute request first clears all 16384 accumulator entries, one entry per cycle, then
// walks the loops: a visited input pixel passes PIX and PIXW, a skipped table entry ENT
// and, unless it lies past the table, ENTW, and an accumulated entry four steps (table
// read, weight and accumulator read, multiply, write back over the single accumulator
// write port), then a keep-mask pass over every entry before the done result is posted.
module table_driven_sparse_conv_forward (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tdsc_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tdsc_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  tdsc_pkg::cmd_t cmd;
  tdsc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  tdsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tdsc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
